// ===== hdl/tcc_pkg.sv =====
// Shared types, constants and the control program of the tiled sparse-to-CSR converter.
`default_nettype none

package tcc_pkg;

  // Field widths
  localparam int ROW_W      = 31;
  localparam int COL_W      = 31;
  localparam int VAL_W      = 64;
  localparam int TROW_W     = 31;
  localparam int BKT_W      = 6;
  localparam int CNT_W      = 32;
  localparam int NROW_W     = 6;
  localparam int LROW_W     = 5;
  localparam int WORD_W     = 32;
  localparam int DIV_W      = 31;
  localparam int DIV_CNT_W  = 5;
  localparam int UPC_W      = 5;

  // Stream and configuration port widths
  localparam int IN_DATA_W   = 136;
  localparam int OUT_USED_W  = 165;
  localparam int OUT_DATA_W  = 168;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARRAY_COLS = 2'd2;

  // Error codes
  localparam logic [WORD_W-1:0] ERR_COLUMN = 32'd1;
  localparam logic [WORD_W-1:0] ERR_ORDER  = 32'd2;
  localparam logic [WORD_W-1:0] ERR_BUCKET = 32'd3;

  typedef enum logic [1:0] {
    KIND_ELEM = 2'd0,
    KIND_PTR  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_ROW,
    OP_LATCH_RT,
    OP_DIV_COL,
    OP_LATCH_B,
    OP_READ,
    OP_LOAD_ST,
    OP_INIT_ENTRY,
    OP_EMIT_PTR,
    OP_EMIT_ELEM,
    OP_WRITE_ENTRY,
    OP_LATCH_FB,
    OP_INIT_FLUSH,
    OP_EMIT_DONE,
    OP_CLEAR,
    OP_ERR_COL,
    OP_ERR_BIG,
    OP_ERR_BKT,
    OP_ERR_ORD
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_NO_INPUT,
    C_IS_FLUSH,
    C_DIV_BUSY,
    C_COL_RANGE,
    C_BIG_BKT,
    C_BKT_RANGE,
    C_FB_RANGE,
    C_ORDER_ERR,
    C_PTR_DONE,
    C_PTR_MORE,
    C_CNT_ZERO
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic in_valid;
    logic is_flush;
    logic div_busy;
    logic col_range;
    logic big_bkt;
    logic bkt_range;
    logic fb_range;
    logic order_err;
    logic ptr_done;
    logic ptr_more;
    logic cnt_zero;
    logic out_free;
  } flags_t;

  // Program step addresses
  localparam logic [UPC_W-1:0] S_FETCH    = 5'd0;
  localparam logic [UPC_W-1:0] S_DISPATCH = 5'd1;
  localparam logic [UPC_W-1:0] S_ROW_DIV  = 5'd2;
  localparam logic [UPC_W-1:0] S_ROW_WAIT = 5'd3;
  localparam logic [UPC_W-1:0] S_ROW_DONE = 5'd4;
  localparam logic [UPC_W-1:0] S_BIG_CHK  = 5'd5;
  localparam logic [UPC_W-1:0] S_COL_DIV  = 5'd6;
  localparam logic [UPC_W-1:0] S_COL_WAIT = 5'd7;
  localparam logic [UPC_W-1:0] S_COL_DONE = 5'd8;
  localparam logic [UPC_W-1:0] S_E_READ   = 5'd9;
  localparam logic [UPC_W-1:0] S_E_LOAD   = 5'd10;
  localparam logic [UPC_W-1:0] S_E_INIT   = 5'd11;
  localparam logic [UPC_W-1:0] S_E_CHK    = 5'd12;
  localparam logic [UPC_W-1:0] S_E_PTR    = 5'd13;
  localparam logic [UPC_W-1:0] S_ELEM     = 5'd14;
  localparam logic [UPC_W-1:0] S_E_WRITE  = 5'd15;
  localparam logic [UPC_W-1:0] S_FL_LATCH = 5'd16;
  localparam logic [UPC_W-1:0] S_F_READ   = 5'd17;
  localparam logic [UPC_W-1:0] S_F_LOAD   = 5'd18;
  localparam logic [UPC_W-1:0] S_F_INIT   = 5'd19;
  localparam logic [UPC_W-1:0] S_F_CHK    = 5'd20;
  localparam logic [UPC_W-1:0] S_F_PTR    = 5'd21;
  localparam logic [UPC_W-1:0] S_DONE     = 5'd22;
  localparam logic [UPC_W-1:0] S_CLEAR    = 5'd23;
  localparam logic [UPC_W-1:0] S_ERR_COL  = 5'd24;
  localparam logic [UPC_W-1:0] S_ERR_BIG  = 5'd25;
  localparam logic [UPC_W-1:0] S_ERR_BKT  = 5'd26;
  localparam logic [UPC_W-1:0] S_ERR_ORD  = 5'd27;

  function automatic logic is_emit(input op_t op);
    logic r;
    unique case (op) inside
      OP_EMIT_PTR, OP_EMIT_ELEM, OP_EMIT_DONE,
      OP_ERR_COL, OP_ERR_BIG, OP_ERR_BKT, OP_ERR_ORD: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Control store
  function automatic ucw_t ucode(input logic [UPC_W-1:0] addr);
    ucw_t w;
    unique case (addr)
      S_FETCH:    w = '{op: OP_ACCEPT,      cond: C_NO_INPUT,  target: S_FETCH};
      S_DISPATCH: w = '{op: OP_NOP,         cond: C_IS_FLUSH,  target: S_FL_LATCH};
      S_ROW_DIV:  w = '{op: OP_DIV_ROW,     cond: C_NEXT,      target: S_FETCH};
      S_ROW_WAIT: w = '{op: OP_NOP,         cond: C_DIV_BUSY,  target: S_ROW_WAIT};
      S_ROW_DONE: w = '{op: OP_LATCH_RT,    cond: C_COL_RANGE, target: S_ERR_COL};
      S_BIG_CHK:  w = '{op: OP_NOP,         cond: C_BIG_BKT,   target: S_ERR_BIG};
      S_COL_DIV:  w = '{op: OP_DIV_COL,     cond: C_NEXT,      target: S_FETCH};
      S_COL_WAIT: w = '{op: OP_NOP,         cond: C_DIV_BUSY,  target: S_COL_WAIT};
      S_COL_DONE: w = '{op: OP_LATCH_B,     cond: C_BKT_RANGE, target: S_ERR_BKT};
      S_E_READ:   w = '{op: OP_READ,        cond: C_NEXT,      target: S_FETCH};
      S_E_LOAD:   w = '{op: OP_LOAD_ST,     cond: C_NEXT,      target: S_FETCH};
      S_E_INIT:   w = '{op: OP_INIT_ENTRY,  cond: C_ORDER_ERR, target: S_ERR_ORD};
      S_E_CHK:    w = '{op: OP_NOP,         cond: C_PTR_DONE,  target: S_ELEM};
      S_E_PTR:    w = '{op: OP_EMIT_PTR,    cond: C_PTR_MORE,  target: S_E_PTR};
      S_ELEM:     w = '{op: OP_EMIT_ELEM,   cond: C_NEXT,      target: S_FETCH};
      S_E_WRITE:  w = '{op: OP_WRITE_ENTRY, cond: C_JUMP,      target: S_FETCH};
      S_FL_LATCH: w = '{op: OP_LATCH_FB,    cond: C_FB_RANGE,  target: S_ERR_BKT};
      S_F_READ:   w = '{op: OP_READ,        cond: C_NEXT,      target: S_FETCH};
      S_F_LOAD:   w = '{op: OP_LOAD_ST,     cond: C_NEXT,      target: S_FETCH};
      S_F_INIT:   w = '{op: OP_INIT_FLUSH,  cond: C_CNT_ZERO,  target: S_DONE};
      S_F_CHK:    w = '{op: OP_NOP,         cond: C_PTR_DONE,  target: S_DONE};
      S_F_PTR:    w = '{op: OP_EMIT_PTR,    cond: C_PTR_MORE,  target: S_F_PTR};
      S_DONE:     w = '{op: OP_EMIT_DONE,   cond: C_NEXT,      target: S_FETCH};
      S_CLEAR:    w = '{op: OP_CLEAR,       cond: C_JUMP,      target: S_FETCH};
      S_ERR_COL:  w = '{op: OP_ERR_COL,     cond: C_JUMP,      target: S_FETCH};
      S_ERR_BIG:  w = '{op: OP_ERR_BIG,     cond: C_JUMP,      target: S_FETCH};
      S_ERR_BKT:  w = '{op: OP_ERR_BKT,     cond: C_JUMP,      target: S_FETCH};
      S_ERR_ORD:  w = '{op: OP_ERR_ORD,     cond: C_JUMP,      target: S_FETCH};
      default:    w = '{op: OP_NOP,         cond: C_JUMP,      target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tiled_coo_to_csr_stream_top.sv =====
// Tiled sparse-entry to CSR stream converter: datapath, bucket store and sequencer.
//
// Input channel s_*: one transaction per sparse entry (s_tuser = 0) or per bucket flush
// (s_tuser = 1). Output channel m_*: CSR results of one input, m_tlast on the final one.
// Configuration channel cfg_*: always ready; write only while the block is idle.
//
// Each input is handled by a microcoded sequencer over a shared restoring divider.
// An entry takes the row / tile_rows division, the column / tile_cols division, a
// bucket read-modify-write over the single-port bucket RAM and the control steps,
// plus one output step for every row pointer it emits. A flush adds one output step
// per row pointer, none for an empty bucket. Errors end the program
// early. One input is in flight at a time; s_tready is high only in the fetch step.
//
// Reset clears the bucket valid bits (all buckets read as empty), loads the default
// registers and returns the sequencer to fetch. When the receiver stalls, the result
// sits in the output register and the sequencer holds on its output step.
`default_nettype none

module tiled_coo_to_csr_stream_top #(
  parameter int MAX_TILE_ROWS = 32,
  parameter int NUM_BUCKETS   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [30:0] row_coord, [61:31] col_coord, [125:62] value_bits, [131:126] flush_bucket
  input  logic [tcc_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [30:0] tile_row_index, [36:31] tile_col_index, [68:37] position,
  // [100:69] word, [164:101] value_out
  output logic [tcc_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [1:0] kind
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast
);
  import tcc_pkg::*;

  localparam int BKT_AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int MEM_W  = CNT_W + NROW_W + TROW_W;
  localparam logic [NROW_W-1:0] MAX_TR    = NROW_W'(MAX_TILE_ROWS);
  localparam logic [BKT_W:0]    NUM_BKT_V = (BKT_W + 1)'(NUM_BUCKETS);

  // Configuration
  logic [NROW_W-1:0] tile_rows;
  logic [COL_W-1:0]  tile_cols;
  logic [COL_W-1:0]  array_cols;
  logic [NROW_W-1:0] tr;
  logic [COL_W-1:0]  tc;

  // Sequencer
  ucw_t   ucw;
  logic   fire;
  flags_t flags;

  // Latched input
  logic              in_act;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [VAL_W-1:0]  in_val;
  logic [BKT_W-1:0]  in_fb;

  // Working registers
  logic [TROW_W-1:0] rt;
  logic [LROW_W-1:0] lr;
  logic [BKT_W-1:0]  b;
  logic [COL_W-1:0]  lcol;
  logic [CNT_W-1:0]  cnt;
  logic [NROW_W-1:0] nrow;
  logic [TROW_W-1:0] rtile;
  logic [NROW_W-1:0] p;
  logic [NROW_W-1:0] plim;
  logic              valid [NUM_BUCKETS];
  logic [BKT_AW-1:0] b_idx;

  // Divider
  logic                 div_start;
  logic [DIV_W-1:0]     div_dvd;
  logic [DIV_W-1:0]     div_rem_in;
  logic [DIV_W-1:0]     div_dsr;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_W-1:0]     div_rem;

  // Bucket store
  logic             ram_we;
  logic             ram_re;
  logic [MEM_W-1:0] ram_wdata;
  logic [MEM_W-1:0] ram_rdata;

  // Result
  logic              out_free;
  logic              emit_fire;
  kind_t             o_kind;
  logic [TROW_W-1:0] o_trow;
  logic [BKT_W-1:0]  o_tcol;
  logic [WORD_W-1:0] o_pos;
  logic [WORD_W-1:0] o_word;
  logic [VAL_W-1:0]  o_val;
  logic              o_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_rows  <= 6'd32;
      tile_cols  <= 31'd1024;
      array_cols <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TILE_ROWS:  tile_rows  <= cfg_data[NROW_W-1:0];
        REG_TILE_COLS:  tile_cols  <= cfg_data;
        REG_ARRAY_COLS: array_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp rows per tile to 1..MAX_TILE_ROWS, columns per tile to at least 1
  always_comb begin
    if (tile_rows == '0) begin
      tr = NROW_W'(1);
    end else if (tile_rows > MAX_TR) begin
      tr = MAX_TR;
    end else begin
      tr = tile_rows;
    end
    tc = (tile_cols == '0) ? COL_W'(1) : tile_cols;
  end

  tcc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ucw   (ucw),
    .fire  (fire)
  );

  assign s_tready = (ucw.op == OP_ACCEPT);
  assign b_idx    = b[BKT_AW-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign emit_fire = fire && is_emit(ucw.op);

  always_comb begin
    flags.in_valid  = s_tvalid;
    flags.is_flush  = in_act;
    flags.div_busy  = div_busy;
    flags.col_range = in_col >= array_cols;
    flags.big_bkt   = {{BKT_W{1'b0}}, in_col} >= {tc, {BKT_W{1'b0}}};
    flags.bkt_range = {1'b0, div_quo[BKT_W-1:0]} >= NUM_BKT_V;
    flags.fb_range  = {1'b0, in_fb} >= NUM_BKT_V;
    flags.order_err = (nrow != '0) &&
                      ((rtile != rt) || (({1'b0, lr} + NROW_W'(1)) < nrow));
    flags.ptr_done  = p > plim;
    flags.ptr_more  = p < plim;
    flags.cnt_zero  = cnt == '0;
    flags.out_free  = out_free;
  end

  // Row division runs over all 31 bits; the column quotient is known to be below 64,
  // so only its low six bits are developed.
  always_comb begin
    div_start = fire && ((ucw.op == OP_DIV_ROW) || (ucw.op == OP_DIV_COL));
    if (ucw.op == OP_DIV_COL) begin
      div_dvd    = {in_col[BKT_W-1:0], {(DIV_W - BKT_W){1'b0}}};
      div_rem_in = {{BKT_W{1'b0}}, in_col[COL_W-1:BKT_W]};
      div_dsr    = tc;
      div_steps  = DIV_CNT_W'(BKT_W);
    end else begin
      div_dvd    = in_row;
      div_rem_in = '0;
      div_dsr    = {{(DIV_W - NROW_W){1'b0}}, tr};
      div_steps  = DIV_CNT_W'(DIV_W);
    end
  end

  tcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dvd_in   (div_dvd),
    .rem_in   (div_rem_in),
    .dsr_in   (div_dsr),
    .steps_in (div_steps),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign ram_we    = fire && (ucw.op == OP_WRITE_ENTRY);
  assign ram_re    = fire && (ucw.op == OP_READ);
  assign ram_wdata = {cnt + CNT_W'(1), {1'b0, lr} + NROW_W'(1), rtile};

  tcc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (b_idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      case (ucw.op)
        OP_ACCEPT: begin
          if (s_tvalid) begin
            in_act <= s_tuser;
            in_row <= s_tdata[30:0];
            in_col <= s_tdata[61:31];
            in_val <= s_tdata[125:62];
            in_fb  <= s_tdata[131:126];
          end
        end
        OP_LATCH_RT: begin
          rt <= div_quo;
          lr <= div_rem[LROW_W-1:0];
        end
        OP_LATCH_B: begin
          b    <= div_quo[BKT_W-1:0];
          lcol <= div_rem;
        end
        OP_LOAD_ST: begin
          // A bucket never written since reset or flush reads as empty
          if (valid[b_idx]) begin
            {cnt, nrow, rtile} <= ram_rdata;
          end else begin
            {cnt, nrow, rtile} <= '0;
          end
        end
        OP_INIT_ENTRY: begin
          p    <= nrow;
          plim <= {1'b0, lr};
          if (nrow == '0) begin
            rtile <= rt;
          end
        end
        OP_EMIT_PTR: p <= p + NROW_W'(1);
        OP_LATCH_FB: b <= in_fb;
        OP_INIT_FLUSH: begin
          p    <= nrow;
          plim <= tr;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (ram_we) begin
      valid[b_idx] <= 1'b1;
    end else if (fire && (ucw.op == OP_CLEAR)) begin
      valid[b_idx] <= 1'b0;
    end
  end

  always_comb begin
    o_kind = KIND_ELEM;
    o_trow = '0;
    o_tcol = '0;
    o_pos  = '0;
    o_word = '0;
    o_val  = '0;
    o_last = 1'b1;
    unique case (ucw.op)
      OP_EMIT_PTR: begin
        o_kind = KIND_PTR;
        o_trow = rtile;
        o_tcol = b;
        o_pos  = WORD_W'(p);
        o_word = cnt;
        o_last = 1'b0;
      end
      OP_EMIT_ELEM: begin
        o_trow = rtile;
        o_tcol = b;
        o_pos  = cnt;
        o_word = {1'b0, lcol};
        o_val  = in_val;
      end
      OP_EMIT_DONE: begin
        o_kind = KIND_DONE;
        o_trow = rtile;
        o_tcol = b;
        o_word = cnt;
      end
      OP_ERR_COL: begin
        o_kind = KIND_ERR;
        o_trow = rt;
        o_word = ERR_COLUMN;
      end
      OP_ERR_BIG: begin
        o_kind = KIND_ERR;
        o_word = ERR_BUCKET;
      end
      OP_ERR_BKT: begin
        o_kind = KIND_ERR;
        o_tcol = b;
        o_word = ERR_BUCKET;
      end
      OP_ERR_ORD: begin
        o_kind = KIND_ERR;
        o_trow = rtile;
        o_tcol = b;
        o_word = ERR_ORDER;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, o_val, o_word, o_pos, o_tcol, o_trow};
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

  a_one_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_we_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, b} < NUM_BKT_V))
    else $error("bucket write beyond store");

  a_ptr_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_PTR)) |-> !m_tlast)
    else $error("row pointer marked last");

endmodule

`default_nettype wire

// ===== hdl/tcc_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module tcc_ram #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcc_div.sv =====
// Restoring divider, one quotient bit per cycle, for a programmable number of bits.
`default_nettype none

module tcc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tcc_pkg::DIV_W-1:0]      dvd_in,
  input  logic [tcc_pkg::DIV_W-1:0]      rem_in,
  input  logic [tcc_pkg::DIV_W-1:0]      dsr_in,
  input  logic [tcc_pkg::DIV_CNT_W-1:0]  steps_in,
  output logic                           busy,
  output logic [tcc_pkg::DIV_W-1:0]      quo,
  output logic [tcc_pkg::DIV_W-1:0]      rem
);
  import tcc_pkg::*;

  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == DIV_CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dvd_in;
      dsr <= dsr_in;
      rem <= rem_in;
      quo <= '0;
      cnt <= steps_in;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcc_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module tcc_seq (
  input  logic             clk,
  input  logic             rst,
  input  tcc_pkg::flags_t  flags,
  output tcc_pkg::ucw_t    ucw,
  output logic             fire
);
  import tcc_pkg::*;

  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  logic             taken;
  logic             stall;

  always_comb begin
    ucw   = ucode(pc);
    // Hold an output step until the result register can take it
    stall = is_emit(ucw.op) && !flags.out_free;
    fire  = !stall;
  end

  always_comb begin
    unique case (ucw.cond)
      C_NEXT:      taken = 1'b0;
      C_JUMP:      taken = 1'b1;
      C_NO_INPUT:  taken = !flags.in_valid;
      C_IS_FLUSH:  taken = flags.is_flush;
      C_DIV_BUSY:  taken = flags.div_busy;
      C_COL_RANGE: taken = flags.col_range;
      C_BIG_BKT:   taken = flags.big_bkt;
      C_BKT_RANGE: taken = flags.bkt_range;
      C_FB_RANGE:  taken = flags.fb_range;
      C_ORDER_ERR: taken = flags.order_err;
      C_PTR_DONE:  taken = flags.ptr_done;
      C_PTR_MORE:  taken = flags.ptr_more;
      C_CNT_ZERO:  taken = flags.cnt_zero;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ucw.target;
    end else begin
      pc_next = pc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire
